// File: rtl/ahdp_pkg.sv
// Shared types and constants for the ASCII hex/decimal number parser.
package ahdp_pkg;

  localparam int VALUE_W        = 64;
  localparam int COUNT_W        = 13;
  localparam int MAX_STRING_LEN = 4096;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_A_LO  = 8'h61;  // 'a'
  localparam logic [7:0] CH_F_LO  = 8'h66;  // 'f'
  localparam logic [7:0] CH_A_UP  = 8'h41;  // 'A'
  localparam logic [7:0] CH_F_UP  = 8'h46;  // 'F'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_STRING_LEN);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_DEC   = 6'b000100,
    PH_HEX   = 6'b001000,
    PH_SPACE = 6'b010000,
    PH_DRAIN = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } char_item_t;

  typedef struct packed {
    value_t parsed_value;
    logic   parse_ok;
    count_t consumed_chars;
  } result_item_t;

endpackage

// File: rtl/ahdp_in_if.sv
// Character channel: one string character per transaction.
interface ahdp_in_if;
  import ahdp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

// File: rtl/ahdp_out_if.sv
// Result channel: one parse result per transaction.
interface ahdp_out_if;
  import ahdp_pkg::*;

  logic   valid;
  logic   ready;
  value_t parsed_value;
  logic   parse_ok;
  count_t consumed_chars;

  modport source (output valid, output parsed_value, output parse_ok,
                  output consumed_chars, input ready);
  modport sink   (input valid, input parsed_value, input parse_ok,
                  input consumed_chars, output ready);
endinterface

// File: rtl/ahdp_in_reg.sv
// Input register stage for the character stream.
module ahdp_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ahdp_pkg::char_item_t in_item,
  output logic                held_valid,
  output ahdp_pkg::char_item_t held_item,
  input  logic                take
);
  import ahdp_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end
endmodule

// File: rtl/ahdp_parse.sv
// Parse state, per-character step logic and result register.
module ahdp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  skip_spaces,
  input  logic                  item_valid,
  input  ahdp_pkg::char_item_t  item,
  output logic                  take,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ahdp_pkg::result_item_t res
);
  import ahdp_pkg::*;

  phase_t parse_phase, parse_phase_next;
  value_t accumulated_value, accumulated_value_next;
  count_t consumed_count, consumed_count_next;

  logic         emit;
  result_item_t emit_item;

  logic [7:0] c;
  logic       last;
  logic       is_dec, is_hex_lo, is_hex_up, is_hex;
  logic [3:0] dec_val, hex_val;
  logic       consumed;
  count_t     count_inc;

  assign c    = item.char_byte;
  assign last = item.end_of_string;

  assign is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex_lo = (c >= CH_A_LO) && (c <= CH_F_LO);
  assign is_hex_up = (c >= CH_A_UP) && (c <= CH_F_UP);
  assign is_hex    = is_dec || is_hex_lo || is_hex_up;
  assign dec_val   = 4'(c - CH_ZERO);

  always_comb begin
    if (is_hex_lo) begin
      hex_val = 4'(c - CH_A_LO + 8'd10);
    end else if (is_hex_up) begin
      hex_val = 4'(c - CH_A_UP + 8'd10);
    end else begin
      hex_val = dec_val;
    end
  end

  assign count_inc = (consumed_count < COUNT_MAX) ? consumed_count + 1'b1 : consumed_count;

  // The result register is free, or is emptied in this cycle.
  assign take = item_valid && (!res_valid || res_ready);

  always_comb begin
    parse_phase_next       = parse_phase;
    accumulated_value_next = accumulated_value;
    consumed_count_next    = consumed_count;
    emit                   = 1'b0;
    emit_item              = '0;
    consumed               = 1'b0;
    case (parse_phase)
      PH_DRAIN: begin
        if (last) begin
          parse_phase_next = PH_FIRST;
        end
      end
      PH_LEAD, PH_DEC, PH_HEX, PH_SPACE: begin
        if (parse_phase == PH_LEAD && c == CH_X && accumulated_value == '0) begin
          parse_phase_next = PH_HEX;
          consumed         = 1'b1;
        end else if ((parse_phase == PH_LEAD || parse_phase == PH_DEC) && is_dec) begin
          accumulated_value_next = (accumulated_value << 3) + (accumulated_value << 1)
                                   + VALUE_W'(dec_val);
          parse_phase_next       = PH_DEC;
          consumed               = 1'b1;
        end else if (parse_phase == PH_HEX && is_hex) begin
          accumulated_value_next = (accumulated_value << 4) + VALUE_W'(hex_val);
          consumed               = 1'b1;
        end else if (skip_spaces && c == CH_SPACE) begin
          parse_phase_next = PH_SPACE;
          consumed         = 1'b1;
        end

        if (consumed) begin
          consumed_count_next = count_inc;
          if (last) begin
            parse_phase_next = PH_FIRST;
            emit             = 1'b1;
            emit_item        = '{accumulated_value_next, 1'b1, count_inc};
          end
        end else begin
          parse_phase_next = last ? PH_FIRST : PH_DRAIN;
          emit             = 1'b1;
          emit_item        = '{accumulated_value, 1'b1, consumed_count};
        end
      end
      default: begin
        // Awaiting the first character; unused codes behave the same.
        if (!is_dec) begin
          parse_phase_next       = last ? PH_FIRST : PH_DRAIN;
          accumulated_value_next = '0;
          consumed_count_next    = '0;
          emit                   = 1'b1;
          emit_item              = '0;
        end else begin
          accumulated_value_next = VALUE_W'(dec_val);
          consumed_count_next    = count_t'(1);
          parse_phase_next       = last ? PH_FIRST : PH_LEAD;
          emit                   = last;
          emit_item              = '{VALUE_W'(dec_val), 1'b1, count_t'(1)};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_FIRST;
      accumulated_value <= '0;
      consumed_count    <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        parse_phase       <= parse_phase_next;
        accumulated_value <= accumulated_value_next;
        consumed_count    <= consumed_count_next;
        res_valid         <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= emit_item;
    end
  end
endmodule

// File: rtl/ascii_hex_decimal_number_parser.sv
// Top level of the ASCII hex/decimal number parser.
//
//  Channel   Direction  Payload                                      Transaction
//  chars     in         char_byte[7:0], end_of_string                valid && ready
//  result    out        parsed_value[63:0], parse_ok, consumed[12:0] valid && ready
//  cfg       in         cfg_wr_data (skip_trailing_spaces)           cfg_wr_en
//
// One character is taken per cycle unless the result stalls; the result for the
// number's last character passes the input register, then the result register.
// Synchronous reset clears the parse state and sets skip_trailing_spaces to 1.
// A stalled result holds the result register; the input register still takes a
// character until it, too, is full.
module ascii_hex_decimal_number_parser (
  input  logic       clk,
  input  logic       rst,
  ahdp_in_if.sink    chars,
  ahdp_out_if.source result,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import ahdp_pkg::*;

  logic         skip_spaces;
  logic         held_valid;
  char_item_t   held_item;
  char_item_t   in_item;
  logic         take;
  result_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_spaces <= 1'b1;
    end else if (cfg_wr_en) begin
      skip_spaces <= cfg_wr_data;
    end
  end

  assign in_item = '{chars.char_byte, chars.end_of_string};

  ahdp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  ahdp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .skip_spaces (skip_spaces),
    .item_valid  (held_valid),
    .item        (held_item),
    .take        (take),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res         (res)
  );

  assign result.parsed_value   = res.parsed_value;
  assign result.parse_ok       = res.parse_ok;
  assign result.consumed_chars = res.consumed_chars;
endmodule

// File: rtl/ahdp_checker.sv
// Port-level assertions for the number parser, bound to the top level.
module ahdp_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    res_valid,
  input logic                    res_ready,
  input ahdp_pkg::value_t        parsed_value,
  input logic                    parse_ok,
  input ahdp_pkg::count_t        consumed_chars
);
  import ahdp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(parsed_value)
      && $stable(parse_ok) && $stable(consumed_chars))
    else $error("stalled result transaction changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !parse_ok |-> parsed_value == '0 && consumed_chars == '0)
    else $error("failed parse carries a value or a count");

  a_ok_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && parse_ok |-> consumed_chars != '0)
    else $error("successful parse consumed nothing");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> consumed_chars <= COUNT_MAX)
    else $error("consumed count above saturation limit");
endmodule

bind ascii_hex_decimal_number_parser ahdp_checker u_ahdp_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .parsed_value   (result.parsed_value),
  .parse_ok       (result.parse_ok),
  .consumed_chars (result.consumed_chars)
);
